FILE: hw/rtl/scfl_pkg.sv
// Shared types and constants of the size-class free-list allocator.
`default_nettype none

package scfl_pkg;

    // Fixed field widths of the request and response beats.
    localparam int unsigned SIZE_W = 32;
    localparam int unsigned ADDR_W = 20;
    localparam int unsigned USE_W  = 21;
    localparam int unsigned LIFE_W = 64;
    localparam int unsigned ALU_W  = 64;

    // Size rounding and block header constants.
    localparam int unsigned ROUND_ADD = 7;
    localparam int unsigned HDR_BYTES = 8;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DELEGATED = 2'd1,
        STAT_OOM       = 2'd2
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [SIZE_W-1:0]  request_size;
        logic [ADDR_W-1:0]  block_address;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  granted_address;
        logic [USE_W-1:0]   bytes_in_use;
        logic [LIFE_W-1:0]  bytes_ever_allocated;
    } rsp_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [ALU_W-1:0]  a;
        logic [ALU_W-1:0]  b;
    } alu_req_t;

    // For a subtract, cout high means a >= b.
    typedef struct packed {
        logic [ALU_W-1:0]  result;
        logic              cout;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_ROUND,
        ST_A_LIMIT,
        ST_A_HEAD,
        ST_A_POP,
        ST_A_NEED,
        ST_A_END,
        ST_A_CHK,
        ST_A_ADDR,
        ST_A_USAGE,
        ST_A_LIFE,
        ST_F_CHECK,
        ST_F_HDR,
        ST_F_HEAD,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scfl_alu.sv
// Shared 64-bit add/subtract unit with carry out, used by the sequencer for its arithmetic steps.
`default_nettype none

module scfl_alu (
    input  scfl_pkg::alu_req_t req,
    output scfl_pkg::alu_rsp_t rsp
);
    import scfl_pkg::*;

    logic [ALU_W-1:0] b_eff;
    logic             cin;
    logic [ALU_W:0]   sum;

    // One adder serves both operations: subtract adds the inverted operand plus one.
    always_comb
    begin
        cin   = (req.op == ALU_SUB);
        b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
        sum   = {1'b0, req.a} + {1'b0, b_eff} + (ALU_W + 1)'(cin);
        rsp.result = sum[ALU_W-1:0];
        rsp.cout   = sum[ALU_W];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/scfl_core.sv
// Allocator sequencer: class-head and header memories, state registers and step control.
`default_nettype none

module scfl_core #(
    parameter int unsigned ARENA_BYTES = 1048576,
    parameter int unsigned SMALL_LIMIT = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  scfl_pkg::req_t     req,
    output logic               res_valid,
    input  logic               res_ready,
    output scfl_pkg::rsp_t     res
);
    import scfl_pkg::*;

    localparam int unsigned NUM_CLASSES = (SMALL_LIMIT + 7) / 8;
    localparam int unsigned CW          = $clog2(NUM_CLASSES);
    localparam int unsigned NUM_SLOTS   = ARENA_BYTES / 8;
    localparam int unsigned SW          = $clog2(NUM_SLOTS);
    localparam int unsigned AW          = $clog2(ARENA_BYTES + 1);
    localparam int unsigned EW          = AW + 1;
    localparam int unsigned SZW         = SIZE_W + 1;
    localparam int unsigned SCW         = (SW + 1 > ADDR_W - 3) ? SW + 1 : ADDR_W - 3;
    localparam logic [CW-1:0] CLR_LAST  = CW'(NUM_CLASSES - 1);

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   rq_reg, rq_next;
    logic [ADDR_W-1:0]   ba_reg, ba_next;
    logic [SZW-1:0]      size_reg, size_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [EW-1:0]       need_reg, need_next;
    logic [EW-1:0]       end_reg, end_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       bump_reg, bump_next;
    logic [USE_W-1:0]    usage_reg, usage_next;
    logic [LIFE_W-1:0]   life_reg, life_next;
    status_t             status_reg, status_next;
    logic                grant_reg, grant_next;
    logic [CW-1:0]       clr_reg, clr_next;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    // Class-head memory: head data address per size class, zero means empty.
    logic [AW-1:0]       head_mem [NUM_CLASSES];
    logic                head_we;
    logic [CW-1:0]       head_wa, head_ra;
    logic [AW-1:0]       head_wd, head_rd;

    // Header memory: one word per 8-byte slot, a size or a free-list link.
    logic [AW-1:0]       hdr_mem [NUM_SLOTS];
    logic                hdr_we;
    logic [SW-1:0]       hdr_wa, hdr_ra;
    logic [AW-1:0]       hdr_wd, hdr_rd;

    logic                acc;
    logic [CW-1:0]       cls;
    logic [CW-1:0]       hdr_cls;
    logic [SW-1:0]       head_rd_slot;
    logic [SW-1:0]       addr_slot;
    logic [ADDR_W-4:0]   fslot_wide;
    logic                fslot_ok;
    logic [AW-1:0]       faddr;

    scfl_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Decoded addresses and indexes.
    always_comb
    begin
        acc          = req_valid && req_ready;
        cls          = size_reg[CW+2:3];
        hdr_cls      = hdr_rd[CW+2:3];
        head_rd_slot = SW'(head_rd[AW-1:3] - (AW-3)'(1));
        addr_slot    = SW'(addr_reg[AW-1:3] - (AW-3)'(1));
        fslot_wide   = ba_reg[ADDR_W-1:3] - (ADDR_W-3)'(1);
        fslot_ok     = (|ba_reg[ADDR_W-1:3]) && (SCW'(fslot_wide) < SCW'(NUM_SLOTS));
        faddr        = AW'({ba_reg[ADDR_W-1:3], 3'b000});
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_reg == CLR_LAST) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = (req.mode == MODE_FREE) ? ST_F_CHECK : ST_A_ROUND;
                end
            end
            ST_A_ROUND: state_next = ST_A_LIMIT;
            ST_A_LIMIT: state_next = alu_rsp.cout ? ST_DONE : ST_A_HEAD;
            ST_A_HEAD:  state_next = (head_rd != '0) ? ST_A_POP : ST_A_NEED;
            ST_A_POP:   state_next = ST_A_USAGE;
            ST_A_NEED:  state_next = ST_A_END;
            ST_A_END:   state_next = ST_A_CHK;
            ST_A_CHK:   state_next = alu_rsp.cout ? ST_A_ADDR : ST_DONE;
            ST_A_ADDR:  state_next = ST_A_USAGE;
            ST_A_USAGE: state_next = ST_A_LIFE;
            ST_A_LIFE:  state_next = ST_DONE;
            ST_F_CHECK: state_next = fslot_ok ? ST_F_HDR : ST_DONE;
            ST_F_HDR:   state_next = alu_rsp.cout ? ST_DONE : ST_F_HEAD;
            ST_F_HEAD:  state_next = ST_DONE;
            ST_DONE:    if (res_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Step outputs: operands of the shared unit, memory ports and handshake.
    always_comb
    begin
        alu_req   = '{op: ALU_ADD, a: '0, b: '0};
        head_we   = 1'b0;
        head_wa   = cls;
        head_wd   = '0;
        head_ra   = cls;
        hdr_we    = 1'b0;
        hdr_wa    = addr_slot;
        hdr_wd    = AW'(size_reg);
        hdr_ra    = head_rd_slot;
        req_ready = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        res.status               = status_reg;
        res.granted_address      = grant_reg ? ADDR_W'(addr_reg) : '0;
        res.bytes_in_use         = usage_reg;
        res.bytes_ever_allocated = life_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                head_we = 1'b1;
                head_wa = clr_reg;
            end
            ST_A_ROUND: alu_req = '{op: ALU_ADD, a: ALU_W'(rq_reg), b: ALU_W'(ROUND_ADD)};
            ST_A_LIMIT:
            begin
                alu_req = '{op: ALU_SUB, a: ALU_W'(size_reg), b: ALU_W'(SMALL_LIMIT)};
            end
            ST_A_POP:
            begin
                head_we = 1'b1;
                head_wd = hdr_rd;
            end
            ST_A_NEED:  alu_req = '{op: ALU_ADD, a: ALU_W'(size_reg), b: ALU_W'(HDR_BYTES)};
            ST_A_END:   alu_req = '{op: ALU_ADD, a: ALU_W'(bump_reg), b: ALU_W'(need_reg)};
            ST_A_CHK:   alu_req = '{op: ALU_SUB, a: ALU_W'(ARENA_BYTES), b: ALU_W'(end_reg)};
            ST_A_ADDR:  alu_req = '{op: ALU_ADD, a: ALU_W'(bump_reg), b: ALU_W'(HDR_BYTES)};
            ST_A_USAGE:
            begin
                hdr_we  = 1'b1;
                alu_req = '{op: ALU_ADD, a: ALU_W'(usage_reg), b: ALU_W'(size_reg)};
            end
            ST_A_LIFE:  alu_req = '{op: ALU_ADD, a: life_reg, b: ALU_W'(size_reg)};
            ST_F_CHECK: hdr_ra = SW'(fslot_wide);
            ST_F_HDR:
            begin
                head_ra = hdr_cls;
                alu_req = '{op: ALU_SUB, a: ALU_W'(hdr_rd), b: ALU_W'(SMALL_LIMIT)};
            end
            ST_F_HEAD:
            begin
                hdr_we  = 1'b1;
                hdr_wa  = slot_reg;
                hdr_wd  = head_rd;
                head_we = 1'b1;
                head_wd = faddr;
                alu_req = '{op: ALU_SUB, a: ALU_W'(usage_reg), b: ALU_W'(size_reg)};
            end
            default:
            begin
                head_we = 1'b0;
            end
        endcase
    end

    // Datapath register updates for each step.
    always_comb
    begin
        rq_next     = rq_reg;
        ba_next     = ba_reg;
        size_next   = size_reg;
        addr_next   = addr_reg;
        need_next   = need_reg;
        end_next    = end_reg;
        slot_next   = slot_reg;
        bump_next   = bump_reg;
        usage_next  = usage_reg;
        life_next   = life_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        clr_next    = clr_reg;
        case (state_reg)
            ST_CLEAR:   clr_next = clr_reg + CW'(1);
            ST_IDLE:
            begin
                if (acc)
                begin
                    rq_next     = req.request_size;
                    ba_next     = req.block_address;
                    status_next = STAT_OK;
                    grant_next  = 1'b0;
                end
            end
            ST_A_ROUND: size_next = {alu_rsp.result[SZW-1:3], 3'b000};
            ST_A_LIMIT: if (alu_rsp.cout) status_next = STAT_DELEGATED;
            ST_A_HEAD:  addr_next = head_rd;
            ST_A_NEED:  need_next = EW'(alu_rsp.result);
            ST_A_END:   end_next = EW'(alu_rsp.result);
            ST_A_CHK:   if (!alu_rsp.cout) status_next = STAT_OOM;
            ST_A_ADDR:
            begin
                addr_next = AW'(alu_rsp.result);
                bump_next = AW'(end_reg);
            end
            ST_A_USAGE:
            begin
                // Saturate at the top of the usage counter.
                usage_next = (|alu_rsp.result[ALU_W-1:USE_W]) ? '1
                                                              : alu_rsp.result[USE_W-1:0];
            end
            ST_A_LIFE:
            begin
                life_next  = alu_rsp.result;
                grant_next = 1'b1;
            end
            ST_F_CHECK: slot_next = SW'(fslot_wide);
            ST_F_HDR:
            begin
                size_next = SZW'(hdr_rd);
                if (alu_rsp.cout) status_next = STAT_DELEGATED;
            end
            ST_F_HEAD:
            begin
                // Clamp at zero when more is freed than is counted in use.
                usage_next = alu_rsp.cout ? alu_rsp.result[USE_W-1:0] : '0;
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            bump_reg   <= '0;
            usage_reg  <= '0;
            life_reg   <= '0;
            status_reg <= STAT_OK;
            grant_reg  <= 1'b0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            bump_reg   <= bump_next;
            usage_reg  <= usage_next;
            life_reg   <= life_next;
            status_reg <= status_next;
            grant_reg  <= grant_next;
            clr_reg    <= clr_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        rq_reg   <= rq_next;
        ba_reg   <= ba_next;
        size_reg <= size_next;
        addr_reg <= addr_next;
        need_reg <= need_next;
        end_reg  <= end_next;
        slot_reg <= slot_next;
    end

    // Class-head memory with registered read.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd <= head_mem[head_ra];
    end

    // Header memory with registered read.
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[hdr_wa] <= hdr_wd;
        end
        hdr_rd <= hdr_mem[hdr_ra];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/size_class_free_list_allocator_unit.sv
// Top level of the size-class free-list allocator: sequencer core and output register.
// An allocate rounds the size and checks the small limit, then pops its class list or carves
// from the bump pointer; a free reads the block header and pushes the block on its list.
// One request at a time: the next beat can be taken in the cycle after the previous result is
// registered. After reset the class-head memory is cleared one entry a cycle, with in_ready
// low; all counters and the bump pointer reset to zero.
`default_nettype none

module size_class_free_list_allocator_unit #(
    parameter int unsigned ARENA_BYTES = 1048576,
    parameter int unsigned SMALL_LIMIT = 16384
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  scfl_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output scfl_pkg::rsp_t  out_data
);
    import scfl_pkg::*;

    logic  res_valid;
    logic  res_ready;
    rsp_t  res;
    logic  out_valid_reg, out_valid_next;
    rsp_t  out_data_reg, out_data_next;
    logic  load;

    scfl_core #(
        .ARENA_BYTES (ARENA_BYTES),
        .SMALL_LIMIT (SMALL_LIMIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads a finished result when empty or being drained.
    always_comb
    begin
        res_ready      = !out_valid_reg || out_ready;
        load           = res_valid && res_ready;
        out_data_next  = load ? res : out_data_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the size-class free-list allocator unit.
`timescale 1ns / 1ps

module tb_top;
    import scfl_pkg::*;

    localparam int unsigned ARENA_SZ     = 1048576;
    localparam int unsigned SMALL_SZ     = 16384;
    localparam int unsigned CLASS_CNT    = SMALL_SZ / 8;
    localparam int unsigned SLOT_CNT     = ARENA_SZ / 8;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned IDLE_LIMIT   = 12000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [21:0] USE_CEIL     = 22'h1FFFFF;

    // Request mixes of the random phases.
    typedef enum int {
        PROF_SMALL,
        PROF_LARGE,
        PROF_MIXED
    } profile_t;

    // Back-pressure modes of the result channel.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    req_t in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_data;

    size_class_free_list_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the allocator state.
    bit [20:0] free_head [CLASS_CNT];
    bit [20:0] hdr_mem [SLOT_CNT];
    bit        hdr_valid [SLOT_CNT];
    bit [20:0] bump_ptr;
    bit [20:0] used_bytes;
    bit [63:0] total_bytes;
    bit [20:0] carved_blocks[$];
    bit [20:0] live_blocks[$];

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    int unsigned sent_cnt     = 0;
    int unsigned accepted_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned error_cnt    = 0;
    int unsigned idle_cycles  = 0;
    int unsigned burst_left   = 1;
    int unsigned gap_left     = 0;

    rx_mode_t    rx_mode    = RX_ALWAYS;
    int unsigned rx_left    = 0;
    logic [7:0]  rx_pattern = 8'hFF;
    logic [2:0]  rx_phase   = '0;

    // Apply one request to the shadow state and return the response it must produce.
    function automatic rsp_t allocator_step(input req_t rq);
        rsp_t        rsp;
        logic [32:0] rounded;
        logic [20:0] need;
        logic [20:0] blk;
        logic [16:0] slot;
        logic [20:0] stored;
        logic [10:0] cls;
        logic [21:0] sum;
        rsp.status          = STAT_OK;
        rsp.granted_address = '0;
        if (rq.mode == MODE_ALLOC)
        begin
            rounded = ({1'b0, rq.request_size} + 33'd7) & ~33'd7;
            if (rounded >= SMALL_SZ)
            begin
                rsp.status = STAT_DELEGATED;
            end
            else
            begin
                cls = rounded[13:3];
                blk = '0;
                if (free_head[cls] != '0)
                begin
                    // Reuse the head block of the class list.
                    blk            = free_head[cls];
                    free_head[cls] = hdr_mem[blk[20:3] - 18'd1];
                end
                else
                begin
                    // Carve a fresh block behind an 8-byte header.
                    need = rounded[20:0] + 21'd8;
                    if (ARENA_SZ - bump_ptr >= need)
                    begin
                        blk      = bump_ptr + 21'd8;
                        bump_ptr = bump_ptr + need;
                        carved_blocks.push_back(blk);
                    end
                end
                if (blk == '0)
                begin
                    rsp.status = STAT_OOM;
                end
                else
                begin
                    hdr_mem[blk[20:3] - 18'd1]   = rounded[20:0];
                    hdr_valid[blk[20:3] - 18'd1] = 1'b1;
                    sum         = 22'(used_bytes) + 22'(rounded[13:0]);
                    used_bytes  = (sum > USE_CEIL) ? USE_CEIL[20:0] : sum[20:0];
                    total_bytes = total_bytes + 64'(rounded);
                    live_blocks.push_back(blk);
                    rsp.granted_address = blk[19:0];
                end
            end
        end
        else if (rq.block_address >= 20'd8)
        begin
            // Free: the low three address bits do not matter.
            slot   = rq.block_address[19:3] - 17'd1;
            blk    = {slot + 17'd1, 3'b000};
            stored = hdr_mem[slot];
            if (stored >= SMALL_SZ)
            begin
                rsp.status = STAT_DELEGATED;
            end
            else
            begin
                used_bytes     = (used_bytes < stored) ? '0 : used_bytes - stored;
                cls            = stored[13:3];
                hdr_mem[slot]  = free_head[cls];
                free_head[cls] = blk;
                for (int i = 0; i < live_blocks.size(); i++)
                begin
                    if (live_blocks[i] == blk)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
                end
            end
        end
        rsp.bytes_in_use         = used_bytes;
        rsp.bytes_ever_allocated = total_bytes;
        return rsp;
    endfunction

    // An allocate may only pop a list whose head has a written header.
    function automatic bit class_pop_ok(input logic [31:0] sz);
        logic [32:0] rounded;
        logic [20:0] head;
        rounded = ({1'b0, sz} + 33'd7) & ~33'd7;
        if (rounded >= SMALL_SZ)
            return 1'b1;
        head = free_head[rounded[13:3]];
        return (head == '0) || hdr_valid[head[20:3] - 18'd1];
    endfunction

    function automatic logic [31:0] draw_size(input profile_t prof);
        case (prof)
            PROF_SMALL: return $urandom_range(0, 128);
            PROF_LARGE: return ($urandom_range(0, 9) == 0) ? $urandom_range(16369, 16383)
                                                            : $urandom_range(4096, 16383);
            default:    return $urandom_range(0, 2048);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("error at result %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
        error_cnt++;
    endtask

    // Wait until every queued request has been taken by the block.
    task automatic settle();
        while (accepted_cnt != sent_cnt)
            @(negedge clk);
    endtask

    task automatic queue_req(input mode_t md, input logic [31:0] sz, input logic [19:0] ba);
        req_t rq;
        settle();
        rq.mode          = md;
        rq.request_size  = sz;
        rq.block_address = ba;
        pending_reqs.push_back(rq);
        sent_cnt++;
    endtask

    task automatic free_carved(input int unsigned idx, input logic [2:0] low);
        settle();
        queue_req(MODE_FREE, '0, carved_blocks[idx][19:0] | 20'(low));
    endtask

    task automatic random_item(input profile_t prof);
        int unsigned roll;
        int unsigned alloc_pct;
        int unsigned tries;
        logic [31:0] sz;
        logic [19:0] ba;
        settle();
        roll      = $urandom_range(0, 99);
        alloc_pct = (prof == PROF_LARGE) ? 70 : 55;
        if (roll < 2)
        begin
            queue_req(MODE_ALLOC, $urandom(), '0);
        end
        else if (roll < 3)
        begin
            queue_req(MODE_FREE, '0, 20'($urandom_range(0, 7)));
        end
        else if (roll < 5 && carved_blocks.size() != 0)
        begin
            // Any block ever carved, so a repeated free is likely.
            ba = carved_blocks[$urandom_range(0, carved_blocks.size() - 1)][19:0];
            queue_req(MODE_FREE, '0, ba | 20'($urandom_range(0, 7)));
        end
        else if (roll < 5 + alloc_pct || live_blocks.size() == 0)
        begin
            tries = 0;
            do
            begin
                sz = draw_size(prof);
                tries++;
            end while (!class_pop_ok(sz) && tries < 8);
            if (class_pop_ok(sz))
                queue_req(MODE_ALLOC, sz, '0);
            else
                queue_req(MODE_FREE, '0, '0);
        end
        else
        begin
            ba = live_blocks[$urandom_range(0, live_blocks.size() - 1)][19:0];
            queue_req(MODE_FREE, '0, ba | 20'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: bursts of beats separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_rsps.push_back(allocator_step(in_data));
                accepted_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result back-pressure, switching to a random mode after a random run length.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode    = rx_mode_t'($urandom_range(0, 3));
            rx_pattern = 8'($urandom()) | 8'h01;
            rx_left    = $urandom_range(40, 300);
        end
        rx_left--;
        rx_phase = rx_phase + 3'd1;
        case (rx_mode)
            RX_ALWAYS:  out_ready <= 1'b1;
            RX_RANDOM:  out_ready <= ($urandom_range(0, 2) != 0);
            RX_PATTERN: out_ready <= rx_pattern[rx_phase];
            default:    out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Result monitor: compare each beat with the oldest expected response.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                report_mismatch("result with no request outstanding:",
                                64'(out_data.granted_address), '0);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", 64'(out_data.status), 64'(want.status));
                if (out_data.granted_address !== want.granted_address)
                    report_mismatch("granted_address", 64'(out_data.granted_address),
                                    64'(want.granted_address));
                if (out_data.bytes_in_use !== want.bytes_in_use)
                    report_mismatch("bytes_in_use", 64'(out_data.bytes_in_use),
                                    64'(want.bytes_in_use));
                if (out_data.bytes_ever_allocated !== want.bytes_ever_allocated)
                    report_mismatch("bytes_ever_allocated", out_data.bytes_ever_allocated,
                                    want.bytes_ever_allocated);
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any beat on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned phase_left;
        int unsigned phase_idx;
        profile_t    profile;
        phase_left = 0;
        phase_idx  = 0;
        profile    = PROF_SMALL;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Boundary sizes and the delegated cases, including sizes that would wrap.
        queue_req(MODE_ALLOC, 32'd0, '0);
        queue_req(MODE_ALLOC, 32'd1, '0);
        queue_req(MODE_ALLOC, 32'd16376, '0);
        queue_req(MODE_ALLOC, 32'd16376, '0);
        queue_req(MODE_ALLOC, 32'd16377, '0);
        queue_req(MODE_ALLOC, 32'd16384, '0);
        queue_req(MODE_ALLOC, 32'hFFFF_FFFF, '0);
        queue_req(MODE_ALLOC, 32'hFFFF_FFF9, '0);
        // Null addresses are ignored.
        queue_req(MODE_FREE, '0, 20'd0);
        queue_req(MODE_FREE, '0, 20'd7);
        // The second big block links to the first, so a repeated free sees a large header.
        free_carved(3, 3'd0);
        free_carved(2, 3'd5);
        free_carved(2, 3'd0);
        // Repeated frees of small blocks; the last one would drive usage below zero.
        free_carved(0, 3'd0);
        free_carved(1, 3'd3);
        free_carved(1, 3'd0);
        free_carved(1, 3'd7);
        // Pops from the lists built above, corrupted ones included.
        queue_req(MODE_ALLOC, 32'd16370, '0);
        queue_req(MODE_ALLOC, 32'd8, '0);
        queue_req(MODE_ALLOC, 32'd8, '0);
        queue_req(MODE_ALLOC, 32'd0, '0);
        queue_req(MODE_ALLOC, 32'd0, '0);
        queue_req(MODE_ALLOC, 32'd8, '0);

        // Random phases alternate between small, large and mixed request sizes.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                profile    = profile_t'(phase_idx % 3);
                phase_idx  = phase_idx + 1;
                phase_left = $urandom_range(120, 260);
            end
            phase_left--;
            random_item(profile);
        end

        settle();
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/scfl_pkg.sv
hw/rtl/scfl_alu.sv
hw/rtl/scfl_core.sv
hw/rtl/size_class_free_list_allocator_unit.sv
bench/tb_top.sv
